>>> src/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/papp_pkg.sv
// Package for the avoid-point penalty core: constants, register map, stage types.
// No dependencies.
`default_nettype none

package papp_pkg;

    localparam int NUM_STAGES = 65;
    localparam int DIV_STEPS  = 21;
    localparam int SQRT_STEPS = 31;

    // 0.1 in Q24.8, rounded
    localparam logic signed [36:0] TOL_Q8 = 37'sd26;

    typedef enum logic [1:0] {
        REG_AVOID_X    = 2'd0,
        REG_AVOID_Y    = 2'd1,
        REG_AVOID_Z    = 2'd2,
        REG_AVOID_DIST = 2'd3
    } reg_idx_t;

    // divider stage: per-axis remainder and quotient plus carried operands
    typedef struct packed {
        logic [2:0][61:0] rem;
        logic [2:0][20:0] q;
        logic [41:0]      den;
        logic [2:0]       neg;
        logic [3:0]       k;
        logic [2:0][32:0] w;
        logic [2:0][32:0] d;
    } div_t;

    // square-root stage
    typedef struct packed {
        logic [61:0] rem;
        logic [30:0] root;
        logic [2:0]  j;
    } sqrt_t;

endpackage

`default_nettype wire

>>> src/path_avoid_point_penalty_core.sv
// Avoid-point penalty core: stream of 3D segments in, one penalty per segment out.
// Depends on papp_pkg and assert_macros.svh.
// The pipeline has 65 register stages between an accepted request and its result.
// One request per cycle while no result is held unread; depth set by the 21-step quotient and 31-step root.
// The whole pipeline advances together; it halts only while a result is held unread.
// Reset (rst_n, async, low) empties the pipeline and clears all avoid registers to 0.
`default_nettype none

module path_avoid_point_penalty_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // APB configuration
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    // segment requests
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each, low first)
    input  wire logic [191:0]  s_axis_tdata,
    // results
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // extra_time [30:0], zero in bit 31
    output logic      [31:0]   m_axis_tdata
);
    import papp_pkg::*;

    // ---------------- configuration registers ----------------
    logic [31:0] avoid_x_reg, avoid_y_reg, avoid_z_reg;
    logic [30:0] avoid_dist_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avoid_x_reg    <= '0;
            avoid_y_reg    <= '0;
            avoid_z_reg    <= '0;
            avoid_dist_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_AVOID_X:    avoid_x_reg    <= pwdata;
                REG_AVOID_Y:    avoid_y_reg    <= pwdata;
                REG_AVOID_Z:    avoid_z_reg    <= pwdata;
                REG_AVOID_DIST: avoid_dist_reg <= pwdata[30:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_AVOID_X:    prdata = avoid_x_reg;
            REG_AVOID_Y:    prdata = avoid_y_reg;
            REG_AVOID_Z:    prdata = avoid_z_reg;
            REG_AVOID_DIST: prdata = {1'b0, avoid_dist_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // One enable for all stages; the last stage is the output register.
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  pipe_en;

    assign pipe_en       = !vld_reg[NUM_STAGES-1] || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_axis_tvalid};
    end

    // ---------------- stage 0: d = end - start, w = avoid - start ----------------
    logic [2:0][32:0] d1_reg, w1_reg, d1_next, w1_next;
    logic [2:0][31:0] in_s, in_e, av;

    always_comb
    begin
        av = {avoid_z_reg, avoid_y_reg, avoid_x_reg};
        for (int i = 0; i < 3; i++)
        begin
            in_s[i]    = s_axis_tdata[32*i +: 32];
            in_e[i]    = s_axis_tdata[96 + 32*i +: 32];
            d1_next[i] = {in_e[i][31], in_e[i]} - {in_s[i][31], in_s[i]};
            w1_next[i] = {av[i][31], av[i]} - {in_s[i][31], in_s[i]};
        end
    end

    // ---------------- stage 1: common shift k, reduced vectors ----------------
    logic [2:0][32:0] md, mw;
    logic [32:0]      all_dw;
    logic [2:0][19:0] drm, wrm;
    logic [2:0][20:0] dr2_reg, wr2_reg, dr2_next, wr2_next;
    logic [3:0]       k2_reg, k2_next;
    logic [2:0][32:0] d2_reg, w2_reg;

    always_comb
    begin
        all_dw = '0;
        for (int i = 0; i < 3; i++)
        begin
            md[i]  = d1_reg[i][32] ? 33'(-d1_reg[i]) : d1_reg[i];
            mw[i]  = w1_reg[i][32] ? 33'(-w1_reg[i]) : w1_reg[i];
            all_dw = all_dw | md[i] | mw[i];
        end
        // smallest shift that brings every magnitude below 2^20
        k2_next = '0;
        for (int b = 20; b <= 32; b++)
        begin
            if (all_dw[b])
                k2_next = 4'(b - 19);
        end
        for (int i = 0; i < 3; i++)
        begin
            drm[i]      = 20'(md[i] >> k2_next);
            wrm[i]      = 20'(mw[i] >> k2_next);
            dr2_next[i] = d1_reg[i][32] ? 21'(-{1'b0, drm[i]}) : {1'b0, drm[i]};
            wr2_next[i] = w1_reg[i][32] ? 21'(-{1'b0, wrm[i]}) : {1'b0, wrm[i]};
        end
    end

    // ---------------- stage 2: products ----------------
    logic [2:0][41:0] pdd3_reg, pdw3_reg, pdd3_next, pdw3_next;
    logic [2:0][20:0] dr3_reg;
    logic [3:0]       k3_reg;
    logic [2:0][32:0] d3_reg, w3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pdd3_next[i] = 42'($signed(dr2_reg[i]) * $signed(dr2_reg[i]));
            pdw3_next[i] = 42'($signed(dr2_reg[i]) * $signed(wr2_reg[i]));
        end
    end

    // ---------------- stage 3: dot and squared length ----------------
    logic [43:0]      dot4_reg, dot4_next;
    logic [41:0]      den4_reg, den4_next;
    logic [2:0][20:0] dr4_reg;
    logic [3:0]       k4_reg;
    logic [2:0][32:0] d4_reg, w4_reg;

    always_comb
    begin
        dot4_next = {{2{pdw3_reg[0][41]}}, pdw3_reg[0]}
                  + {{2{pdw3_reg[1][41]}}, pdw3_reg[1]}
                  + {{2{pdw3_reg[2][41]}}, pdw3_reg[2]};
        den4_next = pdd3_reg[0] + pdd3_reg[1] + pdd3_reg[2];
    end

    // ---------------- stage 4: numerators, divider entry ----------------
    logic [43:0]      dot_mag;
    logic [2:0][20:0] dr_mag;
    div_t             div_reg [DIV_STEPS+1];
    div_t             div_next [DIV_STEPS+1];
    logic [62:0]      den_sh;

    always_comb
    begin
        dot_mag = dot4_reg[43] ? 44'(-dot4_reg) : dot4_reg;
        div_next[0].den = den4_reg;
        div_next[0].k   = k4_reg;
        div_next[0].w   = w4_reg;
        div_next[0].d   = d4_reg;
        div_next[0].q   = '0;
        for (int i = 0; i < 3; i++)
        begin
            dr_mag[i]            = dr4_reg[i][20] ? 21'(-dr4_reg[i]) : dr4_reg[i];
            div_next[0].rem[i]   = 62'(dot_mag[41:0] * dr_mag[i][19:0]);
            div_next[0].neg[i]   = dot4_reg[43] ^ dr4_reg[i][20];
        end
        // restoring division, one quotient bit per stage, MSB first
        den_sh = '0;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            div_next[s+1] = div_reg[s];
            for (int i = 0; i < 3; i++)
            begin
                den_sh = 63'(div_reg[s].den) << (DIV_STEPS - 1 - s);
                if ({1'b0, div_reg[s].rem[i]} >= den_sh)
                begin
                    div_next[s+1].rem[i] = 62'({1'b0, div_reg[s].rem[i]} - den_sh);
                    div_next[s+1].q[i][DIV_STEPS-1-s] = 1'b1;
                end
            end
        end
    end

    // ---------------- projection offset o = q << k ----------------
    logic [2:0][21:0] q_s;
    logic [2:0][35:0] o_reg, o_next;
    logic [2:0][32:0] d_o_reg, w_o_reg;
    div_t             div_last;

    always_comb
    begin
        div_last = div_reg[DIV_STEPS];
        for (int i = 0; i < 3; i++)
        begin
            q_s[i] = div_last.neg[i] ? 22'(-{1'b0, div_last.q[i]}) : {1'b0, div_last.q[i]};
            if (div_last.den == '0)
                q_s[i] = '0;
            o_next[i] = {{14{q_s[i][21]}}, q_s[i]} << div_last.k;
        end
    end

    // ---------------- tolerance test and both residual candidates ----------------
    logic [2:0][36:0] o_x, od_x, ro_reg, rd_reg, ro_next, rd_next;
    logic [2:0]       axis_out;
    logic             out_reg, out_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_x[i]  = {o_reg[i][35], o_reg[i]};
            od_x[i] = o_x[i] - {{4{d_o_reg[i][32]}}, d_o_reg[i]};
            axis_out[i] = ($signed(o_x[i]) > TOL_Q8 && $signed(od_x[i]) > TOL_Q8) ||
                          ($signed(o_x[i]) < -TOL_Q8 && $signed(od_x[i]) < -TOL_Q8);
            ro_next[i] = {{4{w_o_reg[i][32]}}, w_o_reg[i]} - o_x[i];
            rd_next[i] = {{4{w_o_reg[i][32]}}, w_o_reg[i]}
                       - {{4{d_o_reg[i][32]}}, d_o_reg[i]};
        end
        out_next = |axis_out;
    end

    // ---------------- residual magnitudes ----------------
    logic [2:0][36:0] r_sel, m_reg, m_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_sel[i]  = out_reg ? rd_reg[i] : ro_reg[i];
            m_next[i] = r_sel[i][36] ? 37'(-r_sel[i]) : r_sel[i];
        end
    end

    // ---------------- length shift j ----------------
    logic [36:0]      all_m;
    logic [2:0]       j_reg, j_next, j_sq_reg;
    logic [2:0][29:0] sh_reg, sh_next;

    always_comb
    begin
        all_m = m_reg[0] | m_reg[1] | m_reg[2];
        j_next = '0;
        for (int b = 30; b <= 36; b++)
        begin
            if (all_m[b])
                j_next = 3'(b - 29);
        end
        for (int i = 0; i < 3; i++)
            sh_next[i] = 30'(m_reg[i] >> j_next);
    end

    // ---------------- squares, sum, square root ----------------
    logic [2:0][59:0] sq_reg, sq_next;
    sqrt_t            sqr_reg [SQRT_STEPS+1];
    sqrt_t            sqr_next [SQRT_STEPS+1];
    logic [63:0]      trial;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = 60'(sh_reg[i] * sh_reg[i]);
        sqr_next[0].rem  = 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
        sqr_next[0].root = '0;
        sqr_next[0].j    = j_sq_reg;
        // digit-by-digit root: keep rem = n - root^2
        trial = '0;
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            sqr_next[s+1] = sqr_reg[s];
            trial = (64'(sqr_reg[s].root) << (SQRT_STEPS - s))
                  + (64'd1 << (2 * (SQRT_STEPS - 1 - s)));
            if (64'(sqr_reg[s].rem) >= trial)
            begin
                sqr_next[s+1].rem = 62'(64'(sqr_reg[s].rem) - trial);
                sqr_next[s+1].root[SQRT_STEPS-1-s] = 1'b1;
            end
        end
    end

    // ---------------- shortfall and penalty ----------------
    logic [37:0] dist_len;
    logic [30:0] diff_reg, diff_next;
    logic [30:0] pen_reg, pen_next;

    always_comb
    begin
        dist_len = 38'(sqr_reg[SQRT_STEPS].root) << sqr_reg[SQRT_STEPS].j;
        if (dist_len < 38'(avoid_dist_reg))
            diff_next = 31'(38'(avoid_dist_reg) - dist_len);
        else
            diff_next = '0;
        pen_next = 31'((35'(diff_reg) * 35'd10) >> 8);
    end

    assign m_axis_tdata = {1'b0, pen_reg};

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            d1_reg   <= d1_next;
            w1_reg   <= w1_next;
            dr2_reg  <= dr2_next;
            wr2_reg  <= wr2_next;
            k2_reg   <= k2_next;
            d2_reg   <= d1_reg;
            w2_reg   <= w1_reg;
            pdd3_reg <= pdd3_next;
            pdw3_reg <= pdw3_next;
            dr3_reg  <= dr2_reg;
            k3_reg   <= k2_reg;
            d3_reg   <= d2_reg;
            w3_reg   <= w2_reg;
            dot4_reg <= dot4_next;
            den4_reg <= den4_next;
            dr4_reg  <= dr3_reg;
            k4_reg   <= k3_reg;
            d4_reg   <= d3_reg;
            w4_reg   <= w3_reg;
            for (int s = 0; s <= DIV_STEPS; s++)
                div_reg[s] <= div_next[s];
            o_reg    <= o_next;
            d_o_reg  <= div_last.d;
            w_o_reg  <= div_last.w;
            ro_reg   <= ro_next;
            rd_reg   <= rd_next;
            out_reg  <= out_next;
            m_reg    <= m_next;
            j_reg    <= j_next;
            sh_reg   <= sh_next;
            sq_reg   <= sq_next;
            j_sq_reg <= j_reg;
            for (int s = 0; s <= SQRT_STEPS; s++)
                sqr_reg[s] <= sqr_next[s];
            diff_reg <= diff_next;
            pen_reg  <= pen_next;
        end
    end

    // ---------------- assertions ----------------
`include "assert_macros.svh"

    `ASSERT_IMPLY(a_out_msb_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[31] == 1'b0, "result bit 31 set")
    `ASSERT_IMPLY(a_stall_holds_input, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "request taken during output stall")
    `ASSERT_NEXT(a_entry_advances, clk, rst_n, vld_reg[0] && pipe_en, vld_reg[1], "request lost after entry stage")

endmodule

`default_nettype wire
